// File: hdl/virtual_uart_register_front_unit_macros.svh
// Assertion macros for the virtual UART register front.
// Used by the port checker; no other dependencies.
`ifndef VIRTUAL_UART_REGISTER_FRONT_UNIT_MACROS_SVH
`define VIRTUAL_UART_REGISTER_FRONT_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define UVRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uvrf checker: same-cycle property failed");

// next-cycle implication, disabled in reset
`define UVRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uvrf checker: next-cycle property failed");

`endif

// File: hdl/uvrf_pkg.sv
// Shared types, codes and constants of the virtual UART register front.
// No dependencies.
package uvrf_pkg;

  localparam int NUM_PORTS     = 2;
  localparam int DEC_PORTS     = 2;
  localparam int REGS_PER_PORT = 8;
  localparam int OFS_W         = $clog2(REGS_PER_PORT);
  localparam int PORT_W        = $clog2(DEC_PORTS);
  localparam int QDEPTH        = 2;

  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_READBYTE  = 4'd1;
  localparam logic [3:0] CMD_WRITEBYTE = 4'd2;
  localparam logic [3:0] CMD_SETIER    = 4'd3;
  localparam logic [3:0] CMD_SETFCR    = 4'd4;
  localparam logic [3:0] CMD_SETLCR    = 4'd5;
  localparam logic [3:0] CMD_SETBAUD   = 4'd6;
  localparam logic [3:0] CMD_SETMCR    = 4'd7;
  localparam logic [3:0] CMD_GETLSR    = 4'd8;
  localparam logic [3:0] CMD_GETMSR    = 4'd9;

  localparam logic [OFS_W-1:0] OFS_RBR = 3'd0;
  localparam logic [OFS_W-1:0] OFS_IER = 3'd1;
  localparam logic [OFS_W-1:0] OFS_IIR = 3'd2;
  localparam logic [OFS_W-1:0] OFS_LCR = 3'd3;
  localparam logic [OFS_W-1:0] OFS_MCR = 3'd4;
  localparam logic [OFS_W-1:0] OFS_LSR = 3'd5;
  localparam logic [OFS_W-1:0] OFS_MSR = 3'd6;
  localparam logic [OFS_W-1:0] OFS_SCR = 3'd7;

  localparam logic [1:0] CFG_BACKEND = 2'd0;
  localparam logic [1:0] CFG_PORT0   = 2'd1;
  localparam logic [1:0] CFG_PORT1   = 2'd2;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [15:0] BASE0_RST = 16'h03F8;
  localparam logic [15:0] BASE1_RST = 16'h02F8;
  localparam logic [7:0]  LCR_RST   = 8'h03;
  localparam logic [7:0]  LSR_RST   = 8'h60;
  localparam logic [7:0]  DLL_RST   = 8'h0C;
  localparam logic [7:0]  LSR_KEEP  = 8'h60;
  localparam logic [7:0]  MSR_KEEP  = 8'hF0;
  localparam logic [7:0]  IER_MASK  = 8'h0F;
  localparam logic [7:0]  IIR_VAL   = 8'h01;
  localparam logic [7:0]  MISS_VAL  = 8'hFF;
  localparam int          DLAB_BIT  = 7;

  typedef struct packed {
    logic              action;
    logic              hit;
    logic [PORT_W-1:0] port;
    logic [OFS_W-1:0]  offset;
    logic              linked;
    logic [7:0]        wdata;
    logic [7:0]        rx;
    logic [7:0]        lsr;
    logic [7:0]        msr;
  } uvrf_req_t;

  typedef struct packed {
    logic      valid;
    uvrf_req_t req;
  } uvrf_qhead_t;

endpackage

// File: hdl/virtual_uart_register_front_unit.sv
// Top level of the virtual UART register front: front decode, request queue
// and back execution. Depends on uvrf_pkg, uvrf_front, uvrf_queue, uvrf_back.
//
// Usage:
//  - Input channel (in_valid / in_stall): one guest byte read or write per
//    request, with the backend's received byte and live status bytes.
//  - Result channel (out_valid / out_stall): one result per request, two for a
//    linked line control write that closes the divisor latch with a nonzero
//    divisor (set-LCR then set-baud, out_last marks the final one).
//  - APB-style port: backend_linked at 0x0, port0_base at 0x4, port1_base at
//    0x8; pready is always high. Write only while the block is idle.
//  - An accepted request passes the queue entry, then the back part's output
//    register. Throughput: one request per cycle while out_stall is low; a
//    two-result request holds the output register for both its results.
//  - A 2-entry queue parts decode from execution; in_stall rises when it is
//    full, so a stalled receiver back-pressures the input once 2 requests wait
//    behind the output register (3 requests after an empty block).
//  - Reset (rst_n low, synchronous) restores register defaults, empties the
//    queue and holds in_stall high.
module virtual_uart_register_front_unit import uvrf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_live_line_status,
  input  logic [7:0]  in_live_modem_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_hit,
  output logic [3:0]  out_command,
  output logic        out_port_index,
  output logic [15:0] out_argument,
  output logic        out_last
);

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  uvrf_req_t   q_req;
  uvrf_qhead_t q_head;

  uvrf_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_address           (in_address),
    .in_write_data        (in_write_data),
    .in_rx_byte           (in_rx_byte),
    .in_live_line_status  (in_live_line_status),
    .in_live_modem_status (in_live_modem_status),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_req                (q_req)
  );

  uvrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (q_req),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  uvrf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_hit        (out_hit),
    .out_command    (out_command),
    .out_port_index (out_port_index),
    .out_argument   (out_argument),
    .out_last       (out_last)
  );

endmodule

// File: hdl/uvrf_front.sv
// Front part: configuration registers on the APB-style port and address decode
// of incoming requests into classified queue entries. Depends on uvrf_pkg.
module uvrf_front import uvrf_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_action,
  input  logic [15:0]     in_address,
  input  logic [7:0]      in_write_data,
  input  logic [7:0]      in_rx_byte,
  input  logic [7:0]      in_live_line_status,
  input  logic [7:0]      in_live_modem_status,
  input  logic            q_full,
  output logic            q_push,
  output uvrf_req_t       q_req
);

  logic        linked_r;
  logic [15:0] base0_r;
  logic [15:0] base1_r;
  logic        cfg_wr;
  logic        match0;
  logic        match1;
  logic [15:0] ofs0;
  logic [15:0] ofs1;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      linked_r <= 1'b0;
      base0_r  <= BASE0_RST;
      base1_r  <= BASE1_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        CFG_BACKEND: linked_r <= pwdata[0];
        CFG_PORT0:   base0_r  <= pwdata[15:0];
        CFG_PORT1:   base1_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      CFG_BACKEND: prdata = {31'd0, linked_r};
      CFG_PORT0:   prdata = {16'd0, base0_r};
      CFG_PORT1:   prdata = {16'd0, base1_r};
      default:     prdata = 32'd0;
    endcase
  end

  assign match0 = ({1'b0, in_address} >= {1'b0, base0_r}) &&
                  ({1'b0, in_address} < ({1'b0, base0_r} + 17'(REGS_PER_PORT)));
  assign match1 = (NUM_PORTS > 1) &&
                  ({1'b0, in_address} >= {1'b0, base1_r}) &&
                  ({1'b0, in_address} < ({1'b0, base1_r} + 17'(REGS_PER_PORT)));
  assign ofs0 = in_address - base0_r;
  assign ofs1 = in_address - base1_r;

  // port 0 wins where windows overlap
  always_comb begin
    q_req.action = in_action;
    q_req.hit    = match0 | match1;
    q_req.port   = PORT_W'(!match0 && match1);
    q_req.offset = match0 ? ofs0[OFS_W-1:0] : (match1 ? ofs1[OFS_W-1:0] : '0);
    q_req.linked = linked_r;
    q_req.wdata  = in_write_data;
    q_req.rx     = in_rx_byte;
    q_req.lsr    = in_live_line_status;
    q_req.msr    = in_live_modem_status;
  end

  assign in_stall = q_full | ~rst_n;
  assign q_push   = in_valid & ~in_stall;

endmodule

// File: hdl/uvrf_queue.sv
// Short request queue between front and back parts.
// Depends on uvrf_pkg.
module uvrf_queue import uvrf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  uvrf_req_t   push_req,
  output logic        full,
  input  logic        pop,
  output uvrf_qhead_t head
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  uvrf_req_t          mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  assign full       = (count_r == CNT_W'(QDEPTH));
  assign head.valid = (count_r != '0);
  assign head.req   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (!push && pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_req;
  end

endmodule

// File: hdl/uvrf_back.sv
// Back part: per-port UART register state, request execution and the
// result output register. Depends on uvrf_pkg.
module uvrf_back import uvrf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  uvrf_qhead_t   head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_read_data,
  output logic          out_hit,
  output logic [3:0]    out_command,
  output logic          out_port_index,
  output logic [15:0]   out_argument,
  output logic          out_last
);

  logic [3:0] ier_r [DEC_PORTS];
  logic [7:0] lcr_r [DEC_PORTS];
  logic [7:0] mcr_r [DEC_PORTS];
  logic [7:0] lsr_r [DEC_PORTS];
  logic [7:0] msr_r [DEC_PORTS];
  logic [7:0] scr_r [DEC_PORTS];
  logic [7:0] dll_r [DEC_PORTS];
  logic [7:0] dlm_r [DEC_PORTS];

  logic              out_valid_r;
  logic [7:0]        out_read_data_r;
  logic              out_hit_r;
  logic [3:0]        out_command_r;
  logic              out_port_index_r;
  logic [15:0]       out_argument_r;
  logic              out_last_r;
  logic              pend_r;
  logic [15:0]       baud_div_r;
  logic              baud_port_r;

  logic              slot_free;
  uvrf_req_t         rq;
  logic [PORT_W-1:0] p;
  logic              dlab;
  logic [15:0]       div;
  logic [7:0]        e_rd;
  logic [3:0]        e_cmd;
  logic [15:0]       e_arg;
  logic              e_two;
  logic [3:0]        ier_nxt;
  logic [7:0]        lcr_nxt;
  logic [7:0]        mcr_nxt;
  logic [7:0]        lsr_nxt;
  logic [7:0]        msr_nxt;
  logic [7:0]        scr_nxt;
  logic [7:0]        dll_nxt;
  logic [7:0]        dlm_nxt;
  logic [7:0]        lsr_val;
  logic [7:0]        msr_val;

  assign slot_free = ~out_valid_r | ~out_stall;
  assign pop       = slot_free & ~pend_r & head.valid;
  assign rq        = head.req;
  assign p         = rq.port;
  assign dlab      = lcr_r[p][DLAB_BIT];
  assign div       = {dlm_r[p], dll_r[p]};
  assign lsr_val   = rq.linked ? rq.lsr : lsr_r[p];
  assign msr_val   = rq.linked ? rq.msr : msr_r[p];

  always_comb begin
    e_rd    = 8'd0;
    e_cmd   = CMD_NONE;
    e_arg   = 16'd0;
    e_two   = 1'b0;
    ier_nxt = ier_r[p];
    lcr_nxt = lcr_r[p];
    mcr_nxt = mcr_r[p];
    lsr_nxt = lsr_r[p];
    msr_nxt = msr_r[p];
    scr_nxt = scr_r[p];
    dll_nxt = dll_r[p];
    dlm_nxt = dlm_r[p];
    if (!rq.hit) begin
      e_rd = (rq.action == ACT_WRITE) ? 8'd0 : MISS_VAL;
    end else if (rq.action == ACT_READ) begin
      unique case (rq.offset)
        OFS_RBR: begin
          if (dlab) e_rd = dll_r[p];
          else if (rq.linked) begin
            e_rd  = rq.rx;
            e_cmd = CMD_READBYTE;
          end
        end
        OFS_IER: e_rd = dlab ? dlm_r[p] : {4'd0, ier_r[p]};
        OFS_IIR: e_rd = IIR_VAL;
        OFS_LCR: e_rd = lcr_r[p];
        OFS_MCR: e_rd = mcr_r[p];
        OFS_LSR: begin
          e_rd    = lsr_val;
          e_cmd   = rq.linked ? CMD_GETLSR : CMD_NONE;
          lsr_nxt = lsr_val & LSR_KEEP;
        end
        OFS_MSR: begin
          e_rd    = msr_val;
          e_cmd   = rq.linked ? CMD_GETMSR : CMD_NONE;
          msr_nxt = msr_val & MSR_KEEP;
        end
        default: e_rd = scr_r[p];
      endcase
    end else begin
      unique case (rq.offset)
        OFS_RBR: begin
          if (dlab) dll_nxt = rq.wdata;
          else if (rq.linked) begin
            e_cmd = CMD_WRITEBYTE;
            e_arg = {8'd0, rq.wdata};
          end
        end
        OFS_IER: begin
          if (dlab) dlm_nxt = rq.wdata;
          else begin
            ier_nxt = rq.wdata[3:0];
            if (rq.linked) begin
              e_cmd = CMD_SETIER;
              e_arg = {8'd0, rq.wdata & IER_MASK};
            end
          end
        end
        OFS_IIR: begin
          if (rq.linked) begin
            e_cmd = CMD_SETFCR;
            e_arg = {8'd0, rq.wdata};
          end
        end
        OFS_LCR: begin
          lcr_nxt = rq.wdata;
          if (rq.linked) begin
            e_cmd = CMD_SETLCR;
            e_arg = {8'd0, rq.wdata};
            e_two = dlab & ~rq.wdata[DLAB_BIT] & (div != 16'd0);
          end
        end
        OFS_MCR: begin
          mcr_nxt = rq.wdata;
          if (rq.linked) begin
            e_cmd = CMD_SETMCR;
            e_arg = {8'd0, rq.wdata};
          end
        end
        OFS_LSR, OFS_MSR: ;
        default: scr_nxt = rq.wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      for (int i = 0; i < DEC_PORTS; i++) begin
        ier_r[i] <= 4'd0;
        lcr_r[i] <= LCR_RST;
        mcr_r[i] <= 8'd0;
        lsr_r[i] <= LSR_RST;
        msr_r[i] <= 8'd0;
        scr_r[i] <= 8'd0;
        dll_r[i] <= DLL_RST;
        dlm_r[i] <= 8'd0;
      end
    end else begin
      if (slot_free) out_valid_r <= pend_r | head.valid;
      if (pend_r && slot_free) pend_r <= 1'b0;
      else if (pop) pend_r <= e_two;
      if (pop && rq.hit) begin
        ier_r[p] <= ier_nxt;
        lcr_r[p] <= lcr_nxt;
        mcr_r[p] <= mcr_nxt;
        lsr_r[p] <= lsr_nxt;
        msr_r[p] <= msr_nxt;
        scr_r[p] <= scr_nxt;
        dll_r[p] <= dll_nxt;
        dlm_r[p] <= dlm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_r) begin
        out_read_data_r  <= 8'd0;
        out_hit_r        <= 1'b1;
        out_command_r    <= CMD_SETBAUD;
        out_port_index_r <= baud_port_r;
        out_argument_r   <= baud_div_r;
        out_last_r       <= 1'b1;
      end else if (pop) begin
        out_read_data_r  <= e_rd;
        out_hit_r        <= rq.hit;
        out_command_r    <= e_cmd;
        out_port_index_r <= rq.hit & (p != '0);
        out_argument_r   <= e_arg;
        out_last_r       <= ~e_two;
        baud_div_r       <= div;
        baud_port_r      <= p != '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_hit        = out_hit_r;
  assign out_command    = out_command_r;
  assign out_port_index = out_port_index_r;
  assign out_argument   = out_argument_r;
  assign out_last       = out_last_r;

endmodule

// File: hdl/uvrf_checker.sv
// Port-level checker for the virtual UART register front, bound to the top.
// Depends on uvrf_pkg and virtual_uart_register_front_unit_macros.svh.
`include "virtual_uart_register_front_unit_macros.svh"

module uvrf_checker import uvrf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [3:0]  out_command,
  input logic [15:0] out_argument,
  input logic        out_last
);

  `UVRF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_command) && $stable(out_argument) && $stable(out_last))
  `UVRF_ASSERT_NOW(a_miss_clean, clk, rst_n, out_valid && !out_hit, out_command == CMD_NONE && out_argument == 16'd0 && out_last)
  `UVRF_ASSERT_NOW(a_baud_last, clk, rst_n, out_valid && out_command == CMD_SETBAUD, out_last && out_hit)
  `UVRF_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && !out_last, out_valid && (out_command == CMD_SETLCR || out_command == CMD_SETBAUD))

endmodule

bind virtual_uart_register_front_unit uvrf_checker u_uvrf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_hit      (out_hit),
  .out_command  (out_command),
  .out_argument (out_argument),
  .out_last     (out_last)
);

// File: sim/virtual_uart_register_front_unit_tb.sv
// Self-checking testbench for the virtual UART register front unit: directed
// and random guest byte accesses, checked against a behavioural predictor.
// Depends on uvrf_pkg and virtual_uart_register_front_unit.
`timescale 1ns / 100ps

module virtual_uart_register_front_unit_tb;
  import uvrf_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        hit;
    logic [3:0]  command;
    logic        port_index;
    logic [15:0] argument;
    logic        last;
  } uart_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = ACT_READ;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic [7:0]  in_rx_byte = '0;
  logic [7:0]  in_live_line_status = '0;
  logic [7:0]  in_live_modem_status = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_hit;
  logic [3:0]  out_command;
  logic        out_port_index;
  logic [15:0] out_argument;
  logic        out_last;

  // predictor copy of the configuration and per-port UART registers
  logic        linked_cfg;
  logic [15:0] base0_cfg;
  logic [15:0] base1_cfg;
  logic [3:0]  int_en    [DEC_PORTS];
  logic [7:0]  line_ctl  [DEC_PORTS];
  logic [7:0]  modem_ctl [DEC_PORTS];
  logic [7:0]  line_stat [DEC_PORTS];
  logic [7:0]  modem_stat[DEC_PORTS];
  logic [7:0]  scratch_reg[DEC_PORTS];
  logic [7:0]  div_low   [DEC_PORTS];
  logic [7:0]  div_high  [DEC_PORTS];

  uart_result_t expected_q[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_order = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  virtual_uart_register_front_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_address          (in_address),
    .in_write_data       (in_write_data),
    .in_rx_byte          (in_rx_byte),
    .in_live_line_status (in_live_line_status),
    .in_live_modem_status(in_live_modem_status),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_hit             (out_hit),
    .out_command         (out_command),
    .out_port_index      (out_port_index),
    .out_argument        (out_argument),
    .out_last            (out_last)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic reset_predictor();
    linked_cfg = 1'b0;
    base0_cfg  = BASE0_RST;
    base1_cfg  = BASE1_RST;
    for (int i = 0; i < DEC_PORTS; i++) begin
      int_en[i]      = '0;
      line_ctl[i]    = LCR_RST;
      modem_ctl[i]   = '0;
      line_stat[i]   = LSR_RST;
      modem_stat[i]  = '0;
      scratch_reg[i] = '0;
      div_low[i]     = DLL_RST;
      div_high[i]    = '0;
    end
  endtask

  task automatic expect_result(input logic [7:0] rd, input logic hit, input logic [3:0] cmd,
                               input logic port, input logic [15:0] arg, input logic fin);
    uart_result_t r;
    r.read_data  = rd;
    r.hit        = hit;
    r.command    = cmd;
    r.port_index = port;
    r.argument   = arg;
    r.last       = fin;
    expected_q.push_back(r);
  endtask

  task automatic predict_access(input logic act, input logic [15:0] addr,
                                input logic [7:0] wdata, input logic [7:0] rx,
                                input logic [7:0] lsr_live, input logic [7:0] msr_live);
    int p;
    logic [2:0] ofs;
    logic dlab;
    logic [15:0] divisor;
    logic [7:0] rd;
    logic [3:0] cmd;
    logic [15:0] arg;
    p = -1;
    // window end is not wrapped at 16 bits
    if ({1'b0, addr} >= {1'b0, base0_cfg} &&
        {1'b0, addr} < {1'b0, base0_cfg} + 17'(REGS_PER_PORT))
      p = 0;
    else if ({1'b0, addr} >= {1'b0, base1_cfg} &&
             {1'b0, addr} < {1'b0, base1_cfg} + 17'(REGS_PER_PORT))
      p = 1;
    if (p < 0) begin
      expect_result((act == ACT_READ) ? MISS_VAL : 8'h00, 1'b0, CMD_NONE, 1'b0, '0, 1'b1);
      return;
    end
    ofs  = 3'(addr - ((p == 0) ? base0_cfg : base1_cfg));
    dlab = line_ctl[p][DLAB_BIT];
    rd   = '0;
    cmd  = CMD_NONE;
    arg  = '0;
    if (act == ACT_READ) begin
      case (ofs)
        OFS_RBR: begin
          if (dlab) rd = div_low[p];
          else if (linked_cfg) begin
            rd  = rx;
            cmd = CMD_READBYTE;
          end
        end
        OFS_IER: rd = dlab ? div_high[p] : {4'h0, int_en[p]};
        OFS_IIR: rd = IIR_VAL;
        OFS_LCR: rd = line_ctl[p];
        OFS_MCR: rd = modem_ctl[p];
        OFS_LSR: begin
          if (linked_cfg) begin
            line_stat[p] = lsr_live;
            cmd = CMD_GETLSR;
          end
          rd = line_stat[p];
          line_stat[p] = line_stat[p] & LSR_KEEP;
        end
        OFS_MSR: begin
          if (linked_cfg) begin
            modem_stat[p] = msr_live;
            cmd = CMD_GETMSR;
          end
          rd = modem_stat[p];
          modem_stat[p] = modem_stat[p] & MSR_KEEP;
        end
        default: rd = scratch_reg[p];
      endcase
    end else begin
      case (ofs)
        OFS_RBR: begin
          if (dlab) div_low[p] = wdata;
          else if (linked_cfg) begin
            cmd = CMD_WRITEBYTE;
            arg = {8'h00, wdata};
          end
        end
        OFS_IER: begin
          if (dlab) div_high[p] = wdata;
          else begin
            int_en[p] = wdata[3:0];
            if (linked_cfg) begin
              cmd = CMD_SETIER;
              arg = {8'h00, wdata & IER_MASK};
            end
          end
        end
        OFS_IIR: begin
          if (linked_cfg) begin
            cmd = CMD_SETFCR;
            arg = {8'h00, wdata};
          end
        end
        OFS_LCR: begin
          divisor = {div_high[p], div_low[p]};
          line_ctl[p] = wdata;
          if (linked_cfg) begin
            cmd = CMD_SETLCR;
            arg = {8'h00, wdata};
            // closing the divisor latch with a nonzero divisor also sets the baud rate
            if (dlab && !wdata[DLAB_BIT] && divisor != 16'h0000) begin
              expect_result(8'h00, 1'b1, CMD_SETLCR, p[0], arg, 1'b0);
              cmd = CMD_SETBAUD;
              arg = divisor;
            end
          end
        end
        OFS_MCR: begin
          modem_ctl[p] = wdata;
          if (linked_cfg) begin
            cmd = CMD_SETMCR;
            arg = {8'h00, wdata};
          end
        end
        OFS_LSR, OFS_MSR: ;
        default: scratch_reg[p] = wdata;
      endcase
    end
    expect_result(rd, 1'b1, cmd, p[0], arg, 1'b1);
  endtask

  task automatic send_access(input logic act, input logic [15:0] addr, input logic [7:0] wdata,
                             input logic [7:0] rx, input logic [7:0] lsr_live,
                             input logic [7:0] msr_live);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_action            <= act;
    in_address           <= addr;
    in_write_data        <= wdata;
    in_rx_byte           <= rx;
    in_live_line_status  <= lsr_live;
    in_live_modem_status <= msr_live;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_access(act, addr, wdata, rx, lsr_live, msr_live);
  endtask

  task automatic send_random_payload(input logic act, input logic [15:0] addr);
    send_access(act, addr, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic await_all_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    logic [31:0] readback;
    logic [15:0] mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_BACKEND: begin
        linked_cfg = value[0];
        mask = 16'h0001;
      end
      CFG_PORT0: begin
        base0_cfg = value;
        mask = 16'hFFFF;
      end
      default: begin
        base1_cfg = value;
        mask = 16'hFFFF;
      end
    endcase
    if ((readback[15:0] & mask) !== (value & mask))
      report_mismatch("register readback", readback[15:0] & mask, value & mask);
  endtask

  task automatic set_config(input logic linked, input logic [15:0] b0, input logic [15:0] b1);
    await_all_results();
    write_register(CFG_BACKEND, {15'h0000, linked});
    write_register(CFG_PORT0, b0);
    write_register(CFG_PORT1, b1);
  endtask

  function automatic logic [15:0] pick_base();
    if ($urandom_range(3) == 0) return 16'($urandom_range(16'hFFFF, 16'hFFF0));
    return 16'($urandom);
  endfunction

  // well-formed baud programming: open latch, load divisor, read a random register, close latch
  task automatic program_divisor(input logic [15:0] b);
    logic [7:0] fmt;
    logic [7:0] lo;
    logic [7:0] hi;
    fmt = 8'($urandom_range(8'h7F));
    lo  = 8'($urandom);
    hi  = 8'($urandom);
    if ($urandom_range(3) == 0) begin
      lo = 8'h00;
      hi = 8'h00;
    end
    send_access(ACT_WRITE, b + OFS_LCR, fmt | 8'h80, 8'($urandom), 8'($urandom), 8'($urandom));
    send_access(ACT_WRITE, b + OFS_RBR, lo, 8'($urandom), 8'($urandom), 8'($urandom));
    send_access(ACT_WRITE, b + OFS_IER, hi, 8'($urandom), 8'($urandom), 8'($urandom));
    send_random_payload(ACT_READ, b + 16'($urandom_range(REGS_PER_PORT - 1)));
    send_access(ACT_WRITE, b + OFS_LCR, fmt, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic run_random_accesses(input int count);
    int sent;
    int r;
    logic [15:0] b;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      b = ($urandom_range(1) == 0) ? base0_cfg : base1_cfg;
      if (r < 10) begin
        send_random_payload(1'($urandom), 16'($urandom));
        sent++;
      end else if (r < 16) begin
        send_random_payload(1'($urandom), ($urandom_range(1) == 0) ? b - 16'd1 : b + 16'd8);
        sent++;
      end else if (r < 30) begin
        program_divisor(b);
        sent += 5;
      end else begin
        send_random_payload(1'($urandom), b + 16'($urandom_range(REGS_PER_PORT - 1)));
        sent++;
      end
    end
  endtask

  task automatic test_reset_state();
    for (int i = 0; i < REGS_PER_PORT; i++)
      send_access(ACT_READ, BASE0_RST + 16'(i), 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_access(ACT_READ, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_register_access();
    logic [15:0] b;
    set_config(1'b1, BASE0_RST, BASE1_RST);
    b = BASE1_RST;
    send_access(ACT_WRITE, b + OFS_RBR, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, b + OFS_IER, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, b + OFS_IIR, 8'hA5, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, b + OFS_MCR, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, b + OFS_LSR, 8'h12, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, b + OFS_MSR, 8'h34, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, b + OFS_SCR, 8'h5A, 8'h00, 8'h00, 8'h00);
    send_access(ACT_READ, b + OFS_RBR, 8'h00, 8'hFF, 8'h00, 8'h00);
    send_access(ACT_READ, b + OFS_LSR, 8'h00, 8'h00, 8'hFF, 8'h00);
    send_access(ACT_READ, b + OFS_MSR, 8'h00, 8'h00, 8'h00, 8'hFF);
    // zero divisor: closing the latch gives no baud request
    send_access(ACT_WRITE, b + OFS_LCR, 8'h83, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, b + OFS_RBR, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, b + OFS_IER, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, b + OFS_LCR, 8'h03, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, b + OFS_LCR, 8'h80, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, b + OFS_RBR, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, b + OFS_IER, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_access(ACT_READ, b + OFS_RBR, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(ACT_WRITE, b + OFS_LCR, 8'h03, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int mode);
    logic [15:0] b0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_config(1'b1, BASE0_RST, BASE1_RST);
    run_random_accesses(100);
    case (mode)
      0: set_config(1'b0, 16'h0000, 16'hFFFF);
      1: set_config(1'b0, 16'hFFFA, pick_base());
      default: set_config(1'b0, pick_base(), pick_base());
    endcase
    run_random_accesses(100);
    // overlapping windows, port 0 wins
    b0 = pick_base();
    set_config(1'b1, b0, b0 + 16'($urandom_range(REGS_PER_PORT - 1)));
    run_random_accesses(100);
  endtask

  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(1'b1, BASE0_RST, BASE1_RST);
    hold_order++;
    run_random_accesses(24);
    await_all_results();
    run_random_accesses(8);
  endtask

  always @(posedge clk) begin
    if (hold_order != hold_seen) begin
      hold_seen <= hold_order;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    uart_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_argument, 16'h0000);
      end else begin
        want = expected_q.pop_front();
        if (out_read_data !== want.read_data)
          report_mismatch("read_data", {8'h00, out_read_data}, {8'h00, want.read_data});
        if (out_hit !== want.hit)
          report_mismatch("hit", {15'h0, out_hit}, {15'h0, want.hit});
        if (out_command !== want.command)
          report_mismatch("command", {12'h0, out_command}, {12'h0, want.command});
        if (out_port_index !== want.port_index)
          report_mismatch("port_index", {15'h0, out_port_index}, {15'h0, want.port_index});
        if (out_argument !== want.argument)
          report_mismatch("argument", out_argument, want.argument);
        if (out_last !== want.last)
          report_mismatch("last", {15'h0, out_last}, {15'h0, want.last});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_register_access();
    test_random_traffic(12, 68, 0);
    test_random_traffic(68, 12, 1);
    test_random_traffic(0, 0, 2);
    test_output_hold();
    await_all_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
